/* rtl/usqr_pkg.sv */
// ----------------------------------------------------------------------------
// usqr_pkg
// Shared types and constants of the UTF-8 sort-quote recoder: the work entry
// passed from the decoder front to the byte emitter, and the fixed byte codes.
// ----------------------------------------------------------------------------
`default_nettype none

package usqr_pkg;

	localparam int CP_W = 21;

	// Code point constants
	localparam logic [CP_W-1:0] REPL_CP     = 21'h00FFFD;
	localparam logic [CP_W-1:0] QUOTE_LIMIT = 21'h00D800;
	localparam logic [CP_W-1:0] BMP_MAX     = 21'h00FFFF;
	localparam logic [CP_W-1:0] FIVE_DIGIT  = 21'd10000;

	// Output byte codes
	localparam logic [7:0] BYTE_BSL  = 8'h5C;
	localparam logic [7:0] BYTE_U    = 8'h75;
	localparam logic [7:0] BYTE_ZERO = 8'h30;

	// Decimal weights by digit position; positions above four are unused
	localparam logic [16:0] POW10 [8] = '{
		17'd1, 17'd10, 17'd100, 17'd1000, 17'd10000, 17'd0, 17'd0, 17'd0
	};

	// One decoded input beat: replacement code points before, an optional
	// code point in the middle, replacement code points after.
	typedef struct packed {
		logic [1:0]      pre;
		logic            mid;
		logic [CP_W-1:0] cp;
		logic [1:0]      post;
		logic            last;
	} entry_t;

endpackage

`default_nettype wire

/* rtl/usqr_front.sv */
// ----------------------------------------------------------------------------
// usqr_front
// UTF-8 decoder front: accepts input beats, tracks the open sequence and
// turns each beat that yields code points into one work entry for the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module usqr_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_stall,
	input  wire logic [7:0]      in_byte,
	input  wire logic            end_of_string,
	output      logic            q_valid,
	input  wire logic            q_stall,
	output      usqr_pkg::entry_t q_data
);
	import usqr_pkg::*;

	logic [CP_W-1:0] partial_q, nxt_partial, ext_partial;
	logic [1:0]      need_q, nxt_need;
	logic [1:0]      taken_q, nxt_taken, inc_taken;
	logic            cont, open_seq, accept;
	entry_t          ent;

	assign cont        = (in_byte[7:6] == 2'b10);
	assign open_seq    = (need_q != 2'd0);
	assign ext_partial = {partial_q[CP_W-7:0], in_byte[5:0]};
	assign inc_taken   = taken_q + 2'd1;

	always_comb begin
		ent         = '0;
		nxt_partial = partial_q;
		nxt_need    = need_q;
		nxt_taken   = taken_q;
		if (open_seq && cont) begin
			if (inc_taken >= need_q) begin
				ent.mid     = 1'b1;
				ent.cp      = ext_partial;
				nxt_partial = '0;
				nxt_need    = 2'd0;
				nxt_taken   = 2'd0;
			end else begin
				nxt_partial = ext_partial;
				nxt_taken   = inc_taken;
			end
		end else begin
			// broken sequence: one replacement for the lead and each continuation
			if (open_seq) begin
				ent.pre = inc_taken;
			end
			nxt_partial = '0;
			nxt_need    = 2'd0;
			nxt_taken   = 2'd0;
			priority if (!in_byte[7]) begin
				ent.mid = 1'b1;
				ent.cp  = {13'd0, in_byte};
			end else if (in_byte[7:5] == 3'b110) begin
				nxt_partial = {16'd0, in_byte[4:0]};
				nxt_need    = 2'd1;
			end else if (in_byte[7:4] == 4'b1110) begin
				nxt_partial = {17'd0, in_byte[3:0]};
				nxt_need    = 2'd2;
			end else if (in_byte[7:3] == 5'b11110) begin
				nxt_partial = {18'd0, in_byte[2:0]};
				nxt_need    = 2'd3;
			end else begin
				ent.mid = 1'b1;
				ent.cp  = REPL_CP;
			end
		end
		// flush a sequence left open at string end
		if (end_of_string && nxt_need != 2'd0) begin
			ent.post    = nxt_taken + 2'd1;
			nxt_partial = '0;
			nxt_need    = 2'd0;
			nxt_taken   = 2'd0;
		end
		ent.last = end_of_string;
	end

	assign in_stall = q_stall;
	assign accept   = in_valid && !in_stall;
	assign q_valid  = in_valid && (ent.pre != 2'd0 || ent.mid || ent.post != 2'd0);
	assign q_data   = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			need_q    <= 2'd0;
			taken_q   <= 2'd0;
		end else if (accept) begin
			partial_q <= nxt_partial;
			need_q    <= nxt_need;
			taken_q   <= nxt_taken;
		end
	end

endmodule

`default_nettype wire

/* rtl/usqr_queue.sv */
// ----------------------------------------------------------------------------
// usqr_queue
// Short register queue of work entries between decoder front and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module usqr_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output      logic             wr_stall,
	input  wire usqr_pkg::entry_t wr_data,
	output      logic             rd_valid,
	input  wire logic             rd_stall,
	output      usqr_pkg::entry_t rd_data
);
	import usqr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign wr_stall = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/usqr_back.sv */
// ----------------------------------------------------------------------------
// usqr_back
// Byte emitter: walks the code points of each work entry and writes them out
// one byte per cycle while out_stall is low, as backslash-u decimal or as UTF-8.
// ----------------------------------------------------------------------------
`default_nettype none

module usqr_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_valid,
	output      logic             rd_stall,
	input  wire usqr_pkg::entry_t rd_data,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      logic [7:0]       out_byte,
	output      logic             run_last,
	output      logic             string_last
);
	import usqr_pkg::*;

	// entry bookkeeping
	logic [1:0]      pre_q, post_q;
	logic            mid_q, last_q;
	logic [CP_W-1:0] cp_q;
	// code point being emitted
	logic            em_act_q;
	logic [CP_W-1:0] ecp_q;
	logic [2:0]      step_q;
	logic            quote_q, long_q;
	logic [15:0]     rem_q;
	// output register
	logic            ov_q, rl_q, sl_q;
	logic [7:0]      ob_q;

	logic            adv, fire, at_end, cp_done, ent_more, take, pop, load;
	logic [2:0]      last_step, pos;
	logic [16:0]     pw, sub;
	logic [3:0]      dig;
	logic [7:0]      byte_nx;
	logic [1:0]      src_pre, src_post, new_pre, new_post;
	logic            src_mid, src_last, new_mid;
	logic [CP_W-1:0] src_cp, lcp;
	logic            l_quote, l_long;

	assign adv       = !ov_q || !out_stall;
	assign fire      = em_act_q && adv;
	assign last_step = quote_q ? (long_q ? 3'd6 : 3'd5) : (long_q ? 3'd3 : 3'd2);
	assign at_end    = (step_q == last_step);
	assign cp_done   = fire && at_end;
	assign ent_more  = (pre_q != 2'd0) || mid_q || (post_q != 2'd0);
	assign take      = !em_act_q || (cp_done && !ent_more);
	assign rd_stall  = !take;
	assign pop       = rd_valid && take;
	assign load      = pop || (cp_done && ent_more);

	// decimal digit at the current position, most significant first
	assign pos = long_q ? (3'd6 - step_q) : (3'd5 - step_q);
	assign pw  = POW10[pos];

	always_comb begin
		dig = 4'd0;
		sub = '0;
		for (int d = 1; d < 10; d++) begin
			if ({1'b0, rem_q} >= pw * 17'(d)) begin
				dig = 4'(d);
				sub = pw * 17'(d);
			end
		end
	end

	always_comb begin
		if (quote_q) begin
			unique case (step_q)
				3'd0:    byte_nx = BYTE_BSL;
				3'd1:    byte_nx = BYTE_U;
				default: byte_nx = BYTE_ZERO | {4'd0, dig};
			endcase
		end else if (long_q) begin
			unique case (step_q)
				3'd0:    byte_nx = {5'b11110, ecp_q[20:18]};
				3'd1:    byte_nx = {2'b10, ecp_q[17:12]};
				3'd2:    byte_nx = {2'b10, ecp_q[11:6]};
				default: byte_nx = {2'b10, ecp_q[5:0]};
			endcase
		end else begin
			unique case (step_q)
				3'd0:    byte_nx = {4'hE, ecp_q[15:12]};
				3'd1:    byte_nx = {2'b10, ecp_q[11:6]};
				default: byte_nx = {2'b10, ecp_q[5:0]};
			endcase
		end
	end

	// pick the next code point from a fresh entry or the current one
	always_comb begin
		if (pop) begin
			src_pre  = rd_data.pre;
			src_mid  = rd_data.mid;
			src_cp   = rd_data.cp;
			src_post = rd_data.post;
			src_last = rd_data.last;
		end else begin
			src_pre  = pre_q;
			src_mid  = mid_q;
			src_cp   = cp_q;
			src_post = post_q;
			src_last = last_q;
		end
		new_pre  = src_pre;
		new_mid  = src_mid;
		new_post = src_post;
		priority if (src_pre != 2'd0) begin
			lcp     = REPL_CP;
			new_pre = src_pre - 2'd1;
		end else if (src_mid) begin
			lcp     = src_cp;
			new_mid = 1'b0;
		end else begin
			lcp      = REPL_CP;
			new_post = src_post - 2'd1;
		end
		l_quote = (lcp < QUOTE_LIMIT);
		l_long  = l_quote ? (lcp >= FIVE_DIGIT) : (lcp > BMP_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_act_q <= 1'b0;
			ov_q     <= 1'b0;
			pre_q    <= 2'd0;
			mid_q    <= 1'b0;
			post_q   <= 2'd0;
			last_q   <= 1'b0;
			step_q   <= 3'd0;
		end else begin
			if (load) begin
				em_act_q <= 1'b1;
				step_q   <= 3'd0;
				pre_q    <= new_pre;
				mid_q    <= new_mid;
				post_q   <= new_post;
				last_q   <= src_last;
			end else if (take) begin
				em_act_q <= 1'b0;
			end else if (fire) begin
				step_q <= step_q + 3'd1;
			end
			if (adv) begin
				ov_q <= em_act_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ecp_q   <= lcp;
			quote_q <= l_quote;
			long_q  <= l_long;
			rem_q   <= lcp[15:0];
			cp_q    <= src_cp;
		end else if (fire && quote_q && step_q >= 3'd2) begin
			rem_q <= 16'({1'b0, rem_q} - sub);
		end
		if (adv) begin
			ob_q <= byte_nx;
			rl_q <= at_end && !ent_more;
			sl_q <= at_end && !ent_more && last_q;
		end
	end

	assign out_valid   = ov_q;
	assign out_byte    = ob_q;
	assign run_last    = rl_q;
	assign string_last = sl_q;

endmodule

`default_nettype wire

/* rtl/utf8_sort_quote_recoder.sv */
// ----------------------------------------------------------------------------
// utf8_sort_quote_recoder
// Decodes a UTF-8 byte string into code points, replacing malformed input
// with U+FFFD, and writes each code point below U+D800 as backslash-u and a
// decimal number of at least four digits, any other as UTF-8.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake          | Payload                              | Beat
//  --------+--------------------+--------------------------------------+------------------
//  input   | in_valid/in_stall  | in_byte, end_of_string               | one string byte
//  output  | out_valid/out_stall| out_byte, run_last, string_last      | one output byte
//
// The output side writes one byte per cycle while out_stall is low; an input
// beat yields 6 output bytes for ASCII, 0 to 15 in general. The decoder front
// takes a beat every cycle until the entry queue (QUEUE_DEPTH entries) fills,
// then stalls. Reset is asynchronous and clears the open sequence, the queue
// and the output register; no clearing pass follows. out_stall only holds
// the emitter, never the front directly.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_sort_quote_recoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_string,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [7:0] out_byte,
	output      logic       run_last,
	output      logic       string_last
);
	import usqr_pkg::*;

	// decoded entries: front to queue, queue to emitter
	logic   fq_valid, fq_stall;
	entry_t fq_data;
	logic   qb_valid, qb_stall;
	entry_t qb_data;

	// Decode each accepted byte and push its work entry; absorbed bytes push nothing.
	usqr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.q_valid       (fq_valid),
		.q_stall       (fq_stall),
		.q_data        (fq_data)
	);

	// Hold entries so the front keeps taking bytes while the emitter drains.
	usqr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_stall (fq_stall),
		.wr_data  (fq_data),
		.rd_valid (qb_valid),
		.rd_stall (qb_stall),
		.rd_data  (qb_data)
	);

	// Expand each entry into output bytes, one per cycle while out_stall is low, with
	// no gap between code points or between entries already waiting in the queue.
	usqr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_valid    (qb_valid),
		.rd_stall    (qb_stall),
		.rd_data     (qb_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.string_last (string_last)
	);

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 sort-quote recoder. A shadow decoder
// predicts every output byte and its run and string markers. The bench runs
// directed byte strings first, then random strings that are mostly
// well-formed, with bursty input and a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------

import usqr_pkg::*;

typedef struct packed {
	logic [7:0] data;
	logic       run_end;
	logic       str_end;
} quoted_beat_t;

class recoder_scoreboard;
	quoted_beat_t    expected_q[$];
	logic [7:0]      run_q[$];
	logic [CP_W-1:0] partial_cp;
	logic [1:0]      conts_needed;
	logic [1:0]      conts_taken;
	int              mismatches;
	int              checked;

	function new();
		drop_sequence();
		mismatches = 0;
		checked    = 0;
	endfunction

	function void drop_sequence();
		partial_cp   = '0;
		conts_needed = '0;
		conts_taken  = '0;
	endfunction

	// Append one byte to the run of the current beat.
	function void put_byte(logic [7:0] b);
		run_q = {run_q, b};
	endfunction

	function void put_code_point(logic [CP_W-1:0] cp);
		int unsigned v;
		v = cp;
		if (cp < QUOTE_LIMIT) begin
			put_byte(BYTE_BSL);
			put_byte(BYTE_U);
			if (cp >= FIVE_DIGIT)
				put_byte(BYTE_ZERO + 8'((v / 10000) % 10));
			put_byte(BYTE_ZERO + 8'((v / 1000) % 10));
			put_byte(BYTE_ZERO + 8'((v / 100) % 10));
			put_byte(BYTE_ZERO + 8'((v / 10) % 10));
			put_byte(BYTE_ZERO + 8'(v % 10));
		end else if (cp <= BMP_MAX) begin
			put_byte({4'hE, cp[15:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end else begin
			put_byte({5'b11110, cp[20:18]});
			put_byte({2'b10, cp[17:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end
	endfunction

	// One replacement for the lead byte and one per continuation taken.
	function void flush_open();
		if (conts_needed != 0) begin
			for (int i = 0; i <= conts_taken; i++)
				put_code_point(REPL_CP);
			drop_sequence();
		end
	endfunction

	function void start_byte(logic [7:0] b);
		if (b[7] == 1'b0) begin
			put_code_point({13'd0, b});
		end else if (b[7:5] == 3'b110) begin
			partial_cp   = {16'd0, b[4:0]};
			conts_needed = 2'd1;
			conts_taken  = 2'd0;
		end else if (b[7:4] == 4'b1110) begin
			partial_cp   = {17'd0, b[3:0]};
			conts_needed = 2'd2;
			conts_taken  = 2'd0;
		end else if (b[7:3] == 5'b11110) begin
			partial_cp   = {18'd0, b[2:0]};
			conts_needed = 2'd3;
			conts_taken  = 2'd0;
		end else begin
			put_code_point(REPL_CP);
		end
	endfunction

	// Advance the shadow decoder by one input beat; return how many bytes it owes.
	function int note_input(logic [7:0] b, logic eos);
		int           n;
		quoted_beat_t beat;
		run_q.delete();
		if (conts_needed != 0 && b[7:6] == 2'b10) begin
			partial_cp  = {partial_cp[CP_W-7:0], b[5:0]};
			conts_taken = conts_taken + 2'd1;
			if (conts_taken >= conts_needed) begin
				put_code_point(partial_cp);
				drop_sequence();
			end
		end else begin
			flush_open();
			start_byte(b);
		end
		if (eos)
			flush_open();
		n = run_q.size();
		foreach (run_q[k]) begin
			beat.data    = run_q[k];
			beat.run_end = (k == n - 1);
			beat.str_end = eos && (k == n - 1);
			expected_q   = {expected_q, beat};
		end
		return n;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	task flag_mismatch(string what);
		mismatches++;
		$display("ERROR beat %0d: %s", checked, what);
	endtask

	task check_output(logic [7:0] b, logic rl, logic sl);
		quoted_beat_t want;
		checked++;
		if (expected_q.size() == 0) begin
			flag_mismatch($sformatf("unexpected out_byte %02h", b));
		end else begin
			want = expected_q.pop_front();
			if (b !== want.data)
				flag_mismatch($sformatf("out_byte %02h, want %02h", b, want.data));
			if (rl !== want.run_end)
				flag_mismatch($sformatf("run_last %b, want %b", rl, want.run_end));
			if (sl !== want.str_end)
				flag_mismatch($sformatf("string_last %b, want %b", sl, want.str_end));
		end
	endtask
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUSY_ITEMS     = 480;
	localparam int SETTLE_CYCLES  = 25;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 120;
	localparam int HOLD_AT_BEAT   = 300;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

	// Opening strings, bit 8 marks the string end: plain ASCII extremes, a
	// two-byte letter, the largest five-digit quote, the first code point
	// re-encoded as UTF-8, the largest four-byte pattern, stray bytes, a
	// four-byte sequence broken after two continuations, and a string ending
	// inside a sequence.
	localparam logic [8:0] OPENING [24] = '{
		9'h001, 9'h07F,
		9'h0C3, 9'h0A9,
		9'h0ED, 9'h09F, 9'h0BF,
		9'h0ED, 9'h0A0, 9'h080,
		9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
		9'h080, 9'h0FF, 9'h0F8,
		9'h0F0, 9'h09F, 9'h098, 9'h041,
		9'h0E2, 9'h182,
		9'h15A
	};

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte       = 8'h01;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_stall     = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_last;

	recoder_scoreboard sb;

	int          burst_left  = 1;
	int          busy_items  = 0;
	int          out_beats   = 0;
	int          idle_cycles = 0;
	int          hold_left   = 0;
	int          mode_left   = 0;
	bit          hold_done   = 1'b0;
	bit          paused      = 1'b0;
	stall_mode_t stall_mode  = STALL_NONE;

	utf8_sort_quote_recoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.string_last  (string_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one byte and hold it until the block takes it, then note the beat
	// with the shadow decoder. Close the burst with a random gap when it runs out.
	task automatic offer(input logic [7:0] b, input logic eos);
		int gap;
		in_valid      <= 1'b1;
		in_byte       <= b;
		end_of_string <= eos;
		do
			@(posedge clk);
		while (in_stall);
		void'(sb.note_input(b, eos));
		busy_items++;
		burst_left--;
		if (burst_left <= 0) begin
			// Mix long unbroken bursts with short choppy ones.
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and wait out every expected byte plus the emitter's tail.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] lead_byte(int conts);
		case (conts)
			1:       return {3'b110, 5'($urandom)};
			2:       return {4'b1110, 4'($urandom)};
			default: return {5'b11110, 3'($urandom)};
		endcase
	endfunction

	// Build one random string of code units, mostly well-formed sequences
	// with random payload bits, plus strays, invalid leads and truncations.
	task automatic send_random_string();
		logic [7:0] bytes_q[$];
		int         units;
		int         pick;
		int         conts;
		units = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
		repeat (units) begin
			pick  = $urandom_range(0, 99);
			conts = 0;
			if (pick < 30) begin
				bytes_q = {bytes_q, 8'($urandom_range(1, 127))};
			end else if (pick < 85) begin
				conts = (pick < 50) ? 1 : (pick < 70) ? 2 : 3;
				bytes_q = {bytes_q, lead_byte(conts)};
			end else if (pick < 90) begin
				// stray continuation
				bytes_q = {bytes_q, {2'b10, 6'($urandom)}};
			end else if (pick < 94) begin
				// never a valid lead
				bytes_q = {bytes_q, 8'($urandom_range(8'hF8, 8'hFF))};
			end else begin
				// truncated sequence: the next unit or the string end breaks it
				conts = $urandom_range(1, 3);
				bytes_q = {bytes_q, lead_byte(conts)};
				conts = $urandom_range(0, conts - 1);
			end
			repeat (conts) bytes_q = {bytes_q, {2'b10, 6'($urandom)}};
		end
		foreach (bytes_q[k])
			offer(bytes_q[k], k == bytes_q.size() - 1);
	endtask

	// Check each output beat, then pick the next stall value. Once, with the
	// sender active, hold off for a long stretch so the entry queue fills.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			sb.check_output(out_byte, run_last, string_last);
			out_beats++;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && out_beats >= HOLD_AT_BEAT && in_valid) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 200);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE:     out_stall <= 1'b0;
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
				STALL_PERIODIC: out_stall <= (mode_left % 3 == 0);
				default:        out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d bytes outstanding",
			         idle_cycles, sb.pending());
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[k])
			offer(OPENING[k][7:0], OPENING[k][8]);
		drain();

		// Random strings; count every accepted beat. Pause once halfway
		// until the block has fully drained.
		busy_items = 0;
		while (busy_items < BUSY_ITEMS) begin
			send_random_string();
			if (!paused && busy_items >= BUSY_ITEMS / 2) begin
				paused = 1'b1;
				drain();
			end
		end
		drain();

		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
